// ===== rtl/mws_pkg.sv =====
// ----------------------------------------------------------------------------
// mws_pkg
// Shared types, constants and helper functions for the waveform shaper.
// ----------------------------------------------------------------------------
package mws_pkg;

    typedef enum logic [2:0] {
        WAVE_TRI      = 3'd0,
        WAVE_SAW      = 3'd1,
        WAVE_SQUARE   = 3'd2,
        WAVE_PULSE    = 3'd3,
        WAVE_SINE     = 3'd4,
        WAVE_NOISE    = 3'd5,
        WAVE_SUPERSAW = 3'd6,
        WAVE_RING     = 3'd7
    } t_wave;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_WAVE_SELECT = 2'd0;
    localparam t_cfg_idx CFG_PULSE_DUTY  = 2'd1;
    localparam t_cfg_idx CFG_NOISE_SEED  = 2'd2;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned SINE_W     = 15;

    localparam logic [15:0] DUTY_RESET = 16'd32768;
    localparam logic [15:0] DUTY_MIN   = 16'd3277;
    localparam logic [15:0] DUTY_MAX   = 16'd62259;
    localparam logic [15:0] SAW_DETUNE = 16'd7209;

    localparam logic [31:0] HASH_STEP_MUL = 32'd747796405;
    localparam logic [31:0] HASH_MUL_A    = 32'h7feb352d;
    localparam logic [31:0] HASH_MUL_B    = 32'h846ca68b;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Reciprocals of the Taylor denominators (2n)(2n+1), scaled by 2^TAYLOR_SH
    // and rounded up, so the quotient is exact for dividends below 2^34.
    localparam int unsigned TAYLOR_SH    = 42;
    localparam logic [63:0] TAYLOR_RCP_1 = ((64'd1 << TAYLOR_SH) + 64'd5) / 64'd6;
    localparam logic [63:0] TAYLOR_RCP_2 = ((64'd1 << TAYLOR_SH) + 64'd19) / 64'd20;
    localparam logic [63:0] TAYLOR_RCP_3 = ((64'd1 << TAYLOR_SH) + 64'd41) / 64'd42;
    localparam logic [63:0] TAYLOR_RCP_4 = ((64'd1 << TAYLOR_SH) + 64'd71) / 64'd72;
    localparam logic [63:0] TAYLOR_RCP_5 = ((64'd1 << TAYLOR_SH) + 64'd109) / 64'd110;
    localparam logic [63:0] TAYLOR_RCP_6 = ((64'd1 << TAYLOR_SH) + 64'd155) / 64'd156;
    localparam logic [63:0] TAYLOR_RCP_7 = ((64'd1 << TAYLOR_SH) + 64'd209) / 64'd210;

    localparam logic signed [15:0] FULL_POS = 16'sd32767;
    localparam logic signed [15:0] FULL_NEG = -16'sd32767;

    // Clamp to the symmetric 1.15 range.
    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] res;
        if (v > 32'sd32767) begin
            res = FULL_POS;
        end else if (v < -32'sd32767) begin
            res = FULL_NEG;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // Scaled reciprocal of the denominator of Taylor term n.
    function automatic logic [63:0] taylor_recip(input int n);
        logic [63:0] rcp;
        case (n)
            1:       rcp = TAYLOR_RCP_1;
            2:       rcp = TAYLOR_RCP_2;
            3:       rcp = TAYLOR_RCP_3;
            4:       rcp = TAYLOR_RCP_4;
            5:       rcp = TAYLOR_RCP_5;
            6:       rcp = TAYLOR_RCP_6;
            default: rcp = TAYLOR_RCP_7;
        endcase
        return rcp;
    endfunction

    // Quarter-wave sine entry k of a table with 2^bits steps, Q30 Taylor series.
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k,
                                                     input int unsigned bits);
        logic [63:0]  qtr;
        logic [63:0]  x;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  tv;
        logic [127:0] qv;
        qtr  = 64'd1 << bits;
        x    = (64'(k) * HALF_PI_Q30 + (qtr >> 1)) >> bits;
        term = x;
        sum  = x;
        for (int n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            qv   = 128'(term) * 128'(taylor_recip(n));
            term = qv[TAYLOR_SH +: 64];
            if (n[0]) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        tv = (sum + 64'd16384) >> 15;
        if (tv > 64'd32767) begin
            tv = 64'd32767;
        end
        return tv[SINE_W-1:0];
    endfunction

endpackage

// ===== rtl/mws_sine_rom.sv =====
// ----------------------------------------------------------------------------
// mws_sine_rom
// Quarter-wave sine ROM with two registered read ports.
// ----------------------------------------------------------------------------
module mws_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  logic                        i_clk,
    input  logic [TABLE_BITS:0]         i_addr_a,
    input  logic [TABLE_BITS:0]         i_addr_b,
    output logic [mws_pkg::SINE_W-1:0]  o_data_a,
    output logic [mws_pkg::SINE_W-1:0]  o_data_b
);
    import mws_pkg::*;

    localparam int DEPTH = (1 << TABLE_BITS) + 1;

    logic [SINE_W-1:0] rom_data [0:DEPTH-1];
    logic [SINE_W-1:0] r_data_a;
    logic [SINE_W-1:0] r_data_b;

    for (genvar k = 0; k < DEPTH; k++) begin : g_rom
        assign rom_data[k] = sine_entry(k, TABLE_BITS);
    end

    always_ff @(posedge i_clk) begin
        r_data_a <= rom_data[i_addr_a];
        r_data_b <= rom_data[i_addr_b];
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

// ===== rtl/multi_waveform_shaper.sv =====
// ----------------------------------------------------------------------------
// multi_waveform_shaper
// Stateless oscillator shaping stage: one phase word in, one 1.15 sample out.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle through a five-stage pipeline; busy stays
// low and the result cannot be held off.
// Reset (synchronous, active low): config returns to triangle, duty one half,
// seed zero, and all stage valid bits clear. The sine ROM is constant.
// ----------------------------------------------------------------------------
module multi_waveform_shaper #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int NOISE_STEPS     = 16,
    parameter int SAW_VOICES      = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input word
    input  logic                              start,
    output logic                              busy,
    input  logic [15:0]                       i_phase_frac,
    // result word
    output logic                              o_done,
    output logic signed [15:0]                o_sample_out,
    // config write port
    input  logic                              i_cfg_we,
    input  mws_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [mws_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mws_pkg::*;

    // Sine addressing: 14 fraction bits round to a table step.
    localparam int IDX_W = SINE_TABLE_BITS + 1;
    localparam int SHIFT = 14 - SINE_TABLE_BITS;
    localparam int HALF  = (1 << SHIFT) >> 1;
    localparam int QTR   = 1 << SINE_TABLE_BITS;

    // Noise step index.
    localparam int STEP_W = $clog2(NOISE_STEPS);
    localparam int NP_W   = 16 + STEP_W + 1;

    // Supersaw: signed voice sum, its magnitude, and a reciprocal for the
    // average. SH leaves 3 spare bits so the ceiling reciprocal is exact.
    localparam int SUM_W = 17 + $clog2(SAW_VOICES);
    localparam int MAG_W = SUM_W - 1;
    localparam int SH    = MAG_W + 3;
    localparam int RC_W  = SH + 1;
    localparam logic [RC_W-1:0] RECIP = RC_W'(((64'd1 << SH) + SAW_VOICES - 1) / SAW_VOICES);
    localparam int QP_W  = MAG_W + RC_W;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    t_wave        r_wave_select;
    logic [15:0]  r_pulse_duty;
    logic [31:0]  r_noise_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_select <= WAVE_TRI;
            r_pulse_duty  <= DUTY_RESET;
            r_noise_seed  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WAVE_SELECT: r_wave_select <= t_wave'(i_cfg_data[2:0]);
                CFG_PULSE_DUTY:  r_pulse_duty  <= i_cfg_data[15:0];
                CFG_NOISE_SEED:  r_noise_seed  <= i_cfg_data[31:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // The pipeline never stalls, so a word is taken on every start.
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // Map a phase to {negate, mirrored table index}.
    function automatic logic [IDX_W:0] sine_addr(input logic [15:0] ph);
        logic [14:0]      rem_r;
        logic [IDX_W-1:0] idx;
        rem_r = {1'b0, ph[13:0]} + 15'(HALF);
        idx   = IDX_W'(rem_r >> SHIFT);
        if (ph[14]) begin
            idx = IDX_W'(QTR) - idx;
        end
        return {ph[15], idx};
    endfunction

    // ------------------------------------------------------------------------
    // Stage 1: simple shapes, sine addresses, noise step, saw voice sum
    // ------------------------------------------------------------------------
    logic                     r1_valid;
    t_wave                    r1_mode;
    logic signed [15:0]       r1_simple;
    logic [IDX_W-1:0]         r1_addr1;
    logic [IDX_W-1:0]         r1_addr2;
    logic                     r1_neg1;
    logic                     r1_neg2;
    logic [STEP_W-1:0]        r1_step;
    logic [31:0]              r1_seed31;
    logic signed [SUM_W-1:0]  r1_saw_sum;

    logic signed [15:0]       n_simple;
    logic [IDX_W:0]           n_sa1;
    logic [IDX_W:0]           n_sa2;
    logic [15:0]              n_phase2;
    logic [17:0]              n_phase3;
    logic [NP_W-1:0]          n_step_prod;
    logic signed [SUM_W-1:0]  n_saw_sum;
    logic [15:0]              n_duty;
    logic signed [17:0]       n_tri;
    logic [15:0]              n_voice;

    always_comb begin
        // clamp the duty where it is used; the register keeps what was written
        n_duty = r_pulse_duty;
        if (n_duty < DUTY_MIN) begin
            n_duty = DUTY_MIN;
        end
        if (n_duty > DUTY_MAX) begin
            n_duty = DUTY_MAX;
        end

        if (!i_phase_frac[15]) begin
            n_tri = 18'sd2 * $signed({2'b00, i_phase_frac}) - 18'sd32768;
        end else begin
            n_tri = 18'sd98304 - 18'sd2 * $signed({2'b00, i_phase_frac});
        end

        case (r_wave_select)
            WAVE_TRI:    n_simple = sat16(32'(n_tri));
            WAVE_SAW:    n_simple = $signed({~i_phase_frac[15], i_phase_frac[14:0]});
            WAVE_SQUARE: n_simple = i_phase_frac[15] ? FULL_NEG : FULL_POS;
            WAVE_PULSE:  n_simple = (i_phase_frac < n_duty) ? FULL_POS : FULL_NEG;
            default:     n_simple = FULL_NEG;
        endcase
        // saw of exactly -1.0 saturates
        if (r_wave_select == WAVE_SAW && i_phase_frac == 16'd0) begin
            n_simple = FULL_NEG;
        end

        // second ring oscillator runs at one and a half times the phase
        n_phase3 = {2'b00, i_phase_frac} + {1'b0, i_phase_frac, 1'b0};
        n_phase2 = n_phase3[16:1];
        n_sa1    = sine_addr(i_phase_frac);
        n_sa2    = sine_addr(n_phase2);

        n_step_prod = NP_W'(i_phase_frac) * NP_W'(NOISE_STEPS);

        // sum the detuned saw voices
        n_saw_sum = '0;
        for (int d = 0; d < SAW_VOICES; d++) begin
            n_voice   = i_phase_frac + 16'(d * SAW_DETUNE);
            n_saw_sum = n_saw_sum + SUM_W'($signed({1'b0, n_voice}) - 17'sd32768);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_mode    <= r_wave_select;
        r1_simple  <= n_simple;
        r1_addr1   <= n_sa1[IDX_W-1:0];
        r1_neg1    <= n_sa1[IDX_W];
        r1_addr2   <= n_sa2[IDX_W-1:0];
        r1_neg2    <= n_sa2[IDX_W];
        r1_step    <= n_step_prod[16 +: STEP_W];
        r1_seed31  <= (r_noise_seed << 5) - r_noise_seed;
        r1_saw_sum <= n_saw_sum;
    end

    // ------------------------------------------------------------------------
    // Stage 2: ROM read, hash seed, saw magnitude
    // ------------------------------------------------------------------------
    logic [SINE_W-1:0]  rom_a;
    logic [SINE_W-1:0]  rom_b;

    mws_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .i_clk    (i_clk),
        .i_addr_a (r1_addr1),
        .i_addr_b (r1_addr2),
        .o_data_a (rom_a),
        .o_data_b (rom_b)
    );

    logic                r2_valid;
    t_wave               r2_mode;
    logic signed [15:0]  r2_simple;
    logic                r2_neg1;
    logic                r2_neg2;
    logic [31:0]         r2_hash;
    logic [MAG_W-1:0]    r2_saw_mag;
    logic                r2_saw_neg;

    logic [SUM_W-1:0]    n_saw_abs;

    always_comb begin
        n_saw_abs = r1_saw_sum[SUM_W-1] ? SUM_W'(-r1_saw_sum) : SUM_W'(r1_saw_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_mode    <= r1_mode;
        r2_simple  <= r1_simple;
        r2_neg1    <= r1_neg1;
        r2_neg2    <= r1_neg2;
        r2_hash    <= r1_seed31 + 32'(r1_step) * HASH_STEP_MUL;
        r2_saw_mag <= n_saw_abs[MAG_W-1:0];
        r2_saw_neg <= r1_saw_sum[SUM_W-1];
    end

    // ------------------------------------------------------------------------
    // Stage 3: sign the sines, ring product, first hash round, saw average
    // ------------------------------------------------------------------------
    logic                r3_valid;
    t_wave               r3_mode;
    logic signed [15:0]  r3_simple;
    logic signed [15:0]  r3_sine;
    logic signed [31:0]  r3_prod;
    logic [31:0]         r3_hash;
    logic [MAG_W-1:0]    r3_saw_q;
    logic                r3_saw_neg;

    logic signed [15:0]  n_s1;
    logic signed [15:0]  n_s2;
    logic [31:0]         n_mix1;
    logic [QP_W-1:0]     n_q_prod;

    always_comb begin
        n_s1     = r2_neg1 ? -$signed({1'b0, rom_a}) : $signed({1'b0, rom_a});
        n_s2     = r2_neg2 ? -$signed({1'b0, rom_b}) : $signed({1'b0, rom_b});
        n_mix1   = r2_hash ^ (r2_hash >> 16);
        n_q_prod = QP_W'(r2_saw_mag) * QP_W'(RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_mode    <= r2_mode;
        r3_simple  <= r2_simple;
        r3_sine    <= n_s1;
        r3_prod    <= 32'(n_s1) * 32'(n_s2);
        r3_hash    <= n_mix1 * HASH_MUL_A;
        r3_saw_q   <= n_q_prod[SH +: MAG_W];
        r3_saw_neg <= r2_saw_neg;
    end

    // ------------------------------------------------------------------------
    // Stage 4: round the ring product, second hash round, sign the saw
    // ------------------------------------------------------------------------
    logic                r4_valid;
    t_wave               r4_mode;
    logic signed [15:0]  r4_simple;
    logic signed [15:0]  r4_sine;
    logic signed [15:0]  r4_ring;
    logic signed [15:0]  r4_saw;
    logic [31:0]         r4_hash;

    logic [31:0]         n_mix2;
    logic signed [31:0]  n_ring_rnd;
    logic signed [31:0]  n_saw_val;

    always_comb begin
        n_mix2     = r3_hash ^ (r3_hash >> 15);
        // round half up: floor((prod + 0.5 LSB) / 2^15)
        n_ring_rnd = (r3_prod + 32'sd16384) >>> 15;
        n_saw_val  = $signed({{(32 - MAG_W){1'b0}}, r3_saw_q});
        if (r3_saw_neg) begin
            n_saw_val = -n_saw_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_mode   <= r3_mode;
        r4_simple <= r3_simple;
        r4_sine   <= r3_sine;
        r4_ring   <= sat16(n_ring_rnd);
        r4_saw    <= sat16(n_saw_val);
        r4_hash   <= n_mix2 * HASH_MUL_B;
    end

    // ------------------------------------------------------------------------
    // Stage 5: last hash fold, pick the waveform, drive the result word
    // ------------------------------------------------------------------------
    logic                r_done;
    logic signed [15:0]  r_sample;

    logic [31:0]         n_mix3;
    logic signed [15:0]  n_noise;
    logic signed [15:0]  n_sample;

    always_comb begin
        n_mix3  = r4_hash ^ (r4_hash >> 16);
        // bits 23:8 minus one half: flip the top bit to center the value
        n_noise = $signed({~n_mix3[23], n_mix3[22:8]});
        if (n_noise == -16'sd32768) begin
            n_noise = FULL_NEG;
        end

        case (r4_mode)
            WAVE_TRI,
            WAVE_SAW,
            WAVE_SQUARE,
            WAVE_PULSE:    n_sample = r4_simple;
            WAVE_SINE:     n_sample = r4_sine;
            WAVE_NOISE:    n_sample = n_noise;
            WAVE_SUPERSAW: n_sample = r4_saw;
            WAVE_RING:     n_sample = r4_ring;
            default:       n_sample = r4_ring;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
    end

    assign o_done       = r_done;
    assign o_sample_out = r_sample;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // every accepted word comes out on o_done
    a_latency_fwd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##5 o_done)
        else $error("accepted word did not reach the output after 5 cycles");

    // no result word appears without a matching accepted word
    a_latency_bwd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept && i_rst_n, 5))
        else $error("result word without an accepted input word");

    // saturation never lets the most negative code through
    a_no_min_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_sample_out != -16'sd32768))
        else $error("result word holds an unsaturated -1.0");

    // square and pulse only ever give full scale
    a_two_level : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ($past(r4_mode) == WAVE_SQUARE || $past(r4_mode) == WAVE_PULSE))
        |-> (o_sample_out == FULL_POS || o_sample_out == FULL_NEG))
        else $error("square or pulse word is not at full scale");

endmodule
